@@ hw/rtl/x86enc_pkg.sv @@
// ----------------------------------------------------------------------------
// x86enc_pkg
// Shared types and constants of the IR to x86 instruction encoder.
// ----------------------------------------------------------------------------
package x86enc_pkg;

  // Host register pool
  localparam int HOST_REGS = 6;
  localparam int SLOT_W    = (HOST_REGS > 1) ? $clog2(HOST_REGS) : 1;
  localparam int CNT_W     = $clog2(HOST_REGS + 1);

  // Descriptor queue between allocator and byte emitter
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Byte position within one instruction
  localparam int MAX_BYTES = 5;
  localparam int IDX_W     = $clog2(MAX_BYTES);

  // Encoding constants
  localparam logic [7:0] BYTE_MOV       = 8'h89;
  localparam logic [7:0] BYTE_ADD       = 8'h01;
  localparam logic [7:0] BYTE_SUB       = 8'h29;
  localparam logic [7:0] BYTE_ESC       = 8'h0F;
  localparam logic [7:0] BYTE_IMUL      = 8'hAF;
  localparam logic [1:0] MODRM_REG_MODE = 2'b11;

  typedef enum logic [2:0] {
    OP_MOVE  = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_MUL   = 3'd3,
    OP_HALT  = 3'd4,
    OP_UNSUP = 3'd5
  } op_t;

  // One allocated instruction, ready for encoding
  typedef struct packed {
    op_t        op;
    logic       err;
    logic [2:0] h1;
    logic [2:0] h2;
    logic [2:0] hd;
  } desc_t;

endpackage

@@ hw/rtl/x86enc_front.sv @@
// ----------------------------------------------------------------------------
// x86enc_front
// Register allocator: binds virtual registers to host registers on first use
// and turns each encodable instruction into a descriptor.
// ----------------------------------------------------------------------------
module x86enc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [2:0]           opcode,
  input  logic [7:0]           dest_reg,
  input  logic [7:0]           first_source,
  input  logic [7:0]           second_source,
  output logic                 desc_valid,
  output x86enc_pkg::desc_t    desc
);
  import x86enc_pkg::*;

  typedef logic [HOST_REGS-1:0][7:0] slot_arr_t;

  typedef struct packed {
    logic             ok;
    logic [SLOT_W-1:0] slot;
    slot_arr_t        owner;
    logic [CNT_W-1:0] used;
  } lookup_t;

  slot_arr_t        slot_owner;
  slot_arr_t        slot_owner_next;
  logic [CNT_W-1:0] slots_used;
  logic [CNT_W-1:0] slots_used_next;

  lookup_t r1, r2, r3, s2;
  logic    ok2;
  logic    is_mov;
  logic    encodable;

  function automatic logic [2:0] host_code(logic [SLOT_W-1:0] slot);
    logic [2:0] code;
    code = 3'(slot);
    // ESP and EBP are never handed out
    if (3'(slot) > 3'd3) code = 3'(slot) + 3'd2;
    return code;
  endfunction

  function automatic lookup_t lookup(slot_arr_t owner, logic [CNT_W-1:0] used,
                                     logic [7:0] vreg);
    lookup_t r;
    logic    hit;
    hit     = 1'b0;
    r.ok    = 1'b0;
    r.slot  = '0;
    r.owner = owner;
    r.used  = used;
    for (int i = 0; i < HOST_REGS; i++) begin
      if (!hit && (CNT_W'(i) < used) && (owner[i] == vreg)) begin
        hit    = 1'b1;
        r.slot = SLOT_W'(i);
      end
    end
    if (hit) begin
      r.ok = 1'b1;
    end else if (used < CNT_W'(HOST_REGS)) begin
      r.ok                     = 1'b1;
      r.slot                   = used[SLOT_W-1:0];
      r.owner[used[SLOT_W-1:0]] = vreg;
      r.used                   = used + CNT_W'(1);
    end
    return r;
  endfunction

  always_comb begin
    is_mov    = (op_t'(opcode) == OP_MOVE);
    encodable = (opcode <= 3'(OP_MUL));
    r1  = lookup(slot_owner, slots_used, first_source);
    r2  = lookup(r1.owner, r1.used, second_source);
    // second source is skipped by move and by an earlier failure
    s2  = (r1.ok && !is_mov) ? r2 : r1;
    ok2 = r1.ok && (is_mov || r2.ok);
    r3  = lookup(s2.owner, s2.used, dest_reg);

    slot_owner_next = ok2 ? r3.owner : s2.owner;
    slots_used_next = ok2 ? r3.used  : s2.used;

    desc_valid = accept && encodable;
    desc.op    = op_t'(opcode);
    desc.err   = !(ok2 && r3.ok);
    desc.h1    = host_code(r1.slot);
    desc.h2    = host_code(r2.slot);
    desc.hd    = host_code(r3.slot);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_used <= '0;
    end else if (desc_valid) begin
      slots_used <= slots_used_next;
    end
  end

  always_ff @(posedge clk) begin
    if (desc_valid) begin
      slot_owner <= slot_owner_next;
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    slots_used <= CNT_W'(HOST_REGS))
    else $error("slots_used beyond host register count");

  a_used_monotonic: assert property (@(posedge clk) disable iff (rst)
    !desc_valid |=> slots_used == $past(slots_used))
    else $error("allocation changed without an encodable item");

endmodule

@@ hw/rtl/x86enc_queue.sv @@
// ----------------------------------------------------------------------------
// x86enc_queue
// Small descriptor FIFO that decouples allocation from byte emission.
// ----------------------------------------------------------------------------
module x86enc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  x86enc_pkg::desc_t wdata,
  output logic              q_full,
  input  logic              rd,
  output x86enc_pkg::desc_t rdata,
  output logic              q_empty
);
  import x86enc_pkg::*;

  desc_t             entries [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign q_full  = (count == QCNT_W'(QDEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rdata   = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) wptr <= wptr + QPTR_W'(1);
      if (do_rd) rptr <= rptr + QPTR_W'(1);
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wptr] <= wdata;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("descriptor queue overflow");

endmodule

@@ hw/rtl/x86enc_back.sv @@
// ----------------------------------------------------------------------------
// x86enc_back
// Byte emitter: walks the head descriptor into a result register one code
// byte per cycle while it is empty or popped, then dequeues the descriptor.
// ----------------------------------------------------------------------------
module x86enc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  x86enc_pkg::desc_t q_desc,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        code_byte,
  output logic              last_byte,
  output logic              status
);
  import x86enc_pkg::*;

  localparam logic [IDX_W-1:0] IDX0 = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX1 = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX2 = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX3 = IDX_W'(3);

  logic             out_valid;
  logic [IDX_W-1:0] idx;
  logic             emit;
  logic [7:0]       byte_v;
  logic             last_v;
  logic             status_v;

  function automatic logic [7:0] modrm(logic [2:0] reg_f, logic [2:0] rm_f);
    return {MODRM_REG_MODE, reg_f, rm_f};
  endfunction

  always_comb begin
    byte_v   = '0;
    last_v   = 1'b0;
    status_v = 1'b0;
    if (q_desc.err) begin
      last_v   = 1'b1;
      status_v = 1'b1;
    end else begin
      unique case (q_desc.op)
        OP_MOVE: begin
          byte_v = (idx == IDX0) ? BYTE_MOV : modrm(q_desc.h1, q_desc.hd);
          last_v = (idx != IDX0);
        end
        OP_ADD, OP_SUB: begin
          unique case (idx)
            IDX0:    byte_v = BYTE_MOV;
            IDX1:    byte_v = modrm(q_desc.h1, q_desc.hd);
            IDX2:    byte_v = (q_desc.op == OP_ADD) ? BYTE_ADD : BYTE_SUB;
            default: begin
              byte_v = modrm(q_desc.h2, q_desc.hd);
              last_v = 1'b1;
            end
          endcase
        end
        OP_MUL: begin
          unique case (idx)
            IDX0:    byte_v = BYTE_MOV;
            IDX1:    byte_v = modrm(q_desc.h1, q_desc.hd);
            IDX2:    byte_v = BYTE_ESC;
            IDX3:    byte_v = BYTE_IMUL;
            default: begin
              // imul swaps roles: reg is the destination
              byte_v = modrm(q_desc.hd, q_desc.h2);
              last_v = 1'b1;
            end
          endcase
        end
        default: last_v = 1'b1;
      endcase
    end
  end

  assign emit  = !q_empty && (!out_valid || pop);
  assign q_pop = emit && last_v;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        idx       <= last_v ? '0 : idx + IDX_W'(1);
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      code_byte <= byte_v;
      last_byte <= last_v;
      status    <= status_v;
    end
  end

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> last_byte && (code_byte == 8'd0))
    else $error("error item must be a single zero byte with last mark");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    idx < IDX_W'(MAX_BYTES))
    else $error("byte index past instruction length");

endmodule

@@ hw/rtl/ir_to_x86_instruction_encoder.sv @@
// ----------------------------------------------------------------------------
// ir_to_x86_instruction_encoder
// Encodes IR instructions into 32-bit x86 machine code, one byte per item.
// ----------------------------------------------------------------------------
// An instruction is taken when push is high and the queue has room: the
// allocator binds its virtual registers and posts a descriptor to a
// four-entry queue. The emitter drains that queue at one code byte per
// cycle while the result register is empty or being popped, through a
// single result register, so a move yields 2 code bytes, add and sub 4,
// mul 5, and an allocation failure 1; halt and unsupported opcodes produce
// no item and are taken every cycle the queue has room. Sustained intake is
// thus set by the byte count of each instruction and by the popping side.
module ir_to_x86_instruction_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [2:0] opcode,
  input  logic [7:0] dest_reg,
  input  logic [7:0] first_source,
  input  logic [7:0] second_source,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] code_byte,
  output logic       last_byte,
  output logic       status
);
  import x86enc_pkg::*;

  logic  accept;
  logic  desc_valid;
  desc_t desc;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;
  desc_t q_desc;

  assign full   = q_full;
  assign accept = push && !q_full;

  x86enc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .opcode        (opcode),
    .dest_reg      (dest_reg),
    .first_source  (first_source),
    .second_source (second_source),
    .desc_valid    (desc_valid),
    .desc          (desc)
  );

  x86enc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (desc_valid),
    .wdata   (desc),
    .q_full  (q_full),
    .rd      (q_pop),
    .rdata   (q_desc),
    .q_empty (q_empty)
  );

  x86enc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_desc    (q_desc),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .code_byte (code_byte),
    .last_byte (last_byte),
    .status    (status)
  );

endmodule

@@ tb/ir_to_x86_instruction_encoder_tb.sv @@
// ----------------------------------------------------------------------------
// ir_to_x86_instruction_encoder_tb
// Self-checking bench for the IR to x86 encoder. It sends IR instructions
// through the push/full side and predicts the register bindings and code
// bytes. It pops the results with random stalls and checks every byte, last
// mark and status in order.
// ----------------------------------------------------------------------------
module ir_to_x86_instruction_encoder_tb;
  import x86enc_pkg::*;

  typedef struct {
    bit [7:0] code;
    bit       last;
    bit       status;
  } code_item_t;

  // Tracks host register bindings and the code bytes still owed by the DUT
  class code_byte_ledger;
    code_item_t  pending_bytes[$];
    bit [7:0]    slot_owner[6];
    int unsigned slots_bound;
    int unsigned mismatches;
    int unsigned bytes_checked;
    int unsigned alloc_errors;

    function new();
      slots_bound   = 0;
      mismatches    = 0;
      bytes_checked = 0;
      alloc_errors  = 0;
    endfunction

    function bit [2:0] host_reg(int unsigned slot);
      case (slot)
        0:       return 3'd0;  // EAX
        1:       return 3'd1;  // ECX
        2:       return 3'd2;  // EDX
        3:       return 3'd3;  // EBX
        4:       return 3'd6;  // ESI
        default: return 3'd7;  // EDI
      endcase
    endfunction

    function void owe_item(bit [7:0] code, bit last, bit status);
      code_item_t item;
      item.code   = code;
      item.last   = last;
      item.status = status;
      pending_bytes.insert(pending_bytes.size(), item);
    endfunction

    function bit bind_vreg(input bit [7:0] vreg, output bit [2:0] hreg);
      int unsigned pool;
      pool = (HOST_REGS < 6) ? HOST_REGS : 6;
      hreg = 3'd0;
      for (int unsigned i = 0; i < slots_bound; i++) begin
        if (slot_owner[i] == vreg) begin
          hreg = host_reg(i);
          return 1'b1;
        end
      end
      if (slots_bound >= pool) return 1'b0;
      slot_owner[slots_bound] = vreg;
      hreg = host_reg(slots_bound);
      slots_bound++;
      return 1'b1;
    endfunction

    function void note_instruction(bit [2:0] op, bit [7:0] vd, bit [7:0] v1, bit [7:0] v2);
      bit [2:0] h1, h2, hd;
      bit       ok;
      bit [7:0] seq[5];
      int       n;
      if (op > OP_MUL) return;
      h2 = 3'd0;
      hd = 3'd0;
      // lookups stop at the first failure; earlier bindings are kept
      ok = bind_vreg(v1, h1);
      if (ok && op != OP_MOVE) ok = bind_vreg(v2, h2);
      if (ok) ok = bind_vreg(vd, hd);
      if (!ok) begin
        owe_item(8'h00, 1'b1, 1'b1);
        alloc_errors++;
        return;
      end
      seq[0] = BYTE_MOV;
      seq[1] = {MODRM_REG_MODE, h1, hd};
      n      = 2;
      case (op)
        OP_ADD: begin
          seq[2] = BYTE_ADD;
          seq[3] = {MODRM_REG_MODE, h2, hd};
          n      = 4;
        end
        OP_SUB: begin
          seq[2] = BYTE_SUB;
          seq[3] = {MODRM_REG_MODE, h2, hd};
          n      = 4;
        end
        OP_MUL: begin
          // imul puts the destination in the reg field
          seq[2] = BYTE_ESC;
          seq[3] = BYTE_IMUL;
          seq[4] = {MODRM_REG_MODE, hd, h2};
          n      = 5;
        end
        default: ;
      endcase
      for (int k = 0; k < n; k++) begin
        owe_item(seq[k], (k == n - 1), 1'b0);
      end
    endfunction

    function void check_code_byte(bit [7:0] code, bit last, bit status);
      code_item_t want;
      if (pending_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected item code_byte=%02h last_byte=%0b status=%0b",
                   code, last, status);
        return;
      end
      want = pending_bytes.pop_front();
      bytes_checked++;
      if (code !== want.code || last !== want.last || status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: item %0d exp code_byte=%02h last_byte=%0b status=%0b, got %02h %0b %0b",
                   bytes_checked, want.code, want.last, want.status, code, last, status);
      end
    endfunction
  endclass

  localparam logic [2:0] OP_RSVD6   = 3'd6;
  localparam logic [2:0] OP_RSVD7   = 3'd7;
  localparam int         N_ITEMS    = 350;
  localparam int         QUIET_FROM = 300;
  localparam int         CYCLE_LIMIT = 200000;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [2:0] opcode;
  logic [7:0] dest_reg;
  logic [7:0] first_source;
  logic [7:0] second_source;
  logic       empty;
  logic       pop;
  logic [7:0] code_byte;
  logic       last_byte;
  logic       status;

  code_byte_ledger ledger;
  bit              quiet;
  int unsigned     cycles;
  int unsigned     op_seen[8];
  int unsigned     sent;

  ir_to_x86_instruction_encoder u_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .opcode       (opcode),
    .dest_reg     (dest_reg),
    .first_source (first_source),
    .second_source(second_source),
    .empty        (empty),
    .pop          (pop),
    .code_byte    (code_byte),
    .last_byte    (last_byte),
    .status       (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: sample at the rising edge
  always @(posedge clk) begin
    if (!rst && pop && !empty) ledger.check_code_byte(code_byte, last_byte, status);
  end

  // pop with random stalls
  initial begin
    int unsigned hold;
    hold = 0;
    pop  = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (quiet) begin
        pop <= 1'b1;
      end else if (hold > 0) begin
        pop <= 1'b0;
        hold--;
      end else if ($urandom_range(0, 4) == 0) begin
        pop <= 1'b0;
        hold = $urandom_range(0, 2);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_instr(input logic [2:0] op, input logic [7:0] vd,
                            input logic [7:0] v1, input logic [7:0] v2);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    push          <= 1'b1;
    opcode        <= op;
    dest_reg      <= vd;
    first_source  <= v1;
    second_source <= v2;
    do @(posedge clk); while (full);
    ledger.note_instruction(op, vd, v1, v2);
    op_seen[op]++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(negedge clk); while (ledger.pending_bytes.size() != 0);
  endtask

  // mostly registers that are already bound, so most items encode cleanly
  function automatic logic [7:0] pick_vreg();
    if (ledger.slots_bound > 0 && $urandom_range(0, 99) < 92)
      return ledger.slot_owner[$urandom_range(0, ledger.slots_bound - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [2:0] pick_op();
    if ($urandom_range(0, 99) < 85) return 3'($urandom_range(0, 3));
    return 3'($urandom_range(4, 7));
  endfunction

  initial begin
    logic [2:0] op;
    bit         paused;
    ledger        = new();
    quiet         = 1'b0;
    paused        = 1'b0;
    sent          = 0;
    cycles        = 0;
    rst           = 1'b1;
    push          = 1'b0;
    opcode        = OP_HALT;
    dest_reg      = 8'h00;
    first_source  = 8'h00;
    second_source = 8'h00;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: fill the pool step by step, then hit each failure point
    send_instr(OP_MOVE,  8'h00, 8'h00, 8'h00);  // same vreg twice
    send_instr(OP_ADD,   8'hFF, 8'h00, 8'hFF);
    send_instr(OP_HALT,  8'h12, 8'h34, 8'h56);
    send_instr(OP_UNSUP, 8'hAB, 8'hCD, 8'hEF);
    send_instr(OP_RSVD6, 8'hFF, 8'hFF, 8'hFF);
    send_instr(OP_RSVD7, 8'h00, 8'h77, 8'h88);
    send_instr(OP_SUB,   8'h55, 8'hAA, 8'h55);
    send_instr(OP_MUL,   8'h80, 8'h01, 8'h7F);  // pool runs out at dest
    send_instr(OP_MUL,   8'h7F, 8'h01, 8'hFF);
    send_instr(OP_MOVE,  8'h00, 8'hC3, 8'h00);  // fails at first source
    send_instr(OP_ADD,   8'h55, 8'hAA, 8'hC3);  // fails at second source
    send_instr(OP_SUB,   8'h3C, 8'h7F, 8'h7F);  // fails at dest
    send_instr(OP_MUL,   8'hFF, 8'h00, 8'hAA);
    send_instr(OP_ADD,   8'hAA, 8'hAA, 8'hAA);
    send_instr(OP_MOVE,  8'h7F, 8'h01, 8'h3C);
    send_instr(OP_SUB,   8'h01, 8'h7F, 8'h00);
    send_instr(OP_MUL,   8'h00, 8'h00, 8'h00);
    send_instr(OP_HALT,  8'h00, 8'hFF, 8'hFF);

    while (sent < N_ITEMS) begin
      if (!paused && sent == N_ITEMS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      if (sent >= QUIET_FROM) quiet = 1'b1;
      op = pick_op();
      send_instr(op, pick_vreg(), pick_vreg(), pick_vreg());
      sent++;
    end

    wait_drained();
    repeat (20) @(negedge clk);

    $display("Sent %0d move, %0d add, %0d sub, %0d mul, %0d no-op instructions",
             op_seen[OP_MOVE], op_seen[OP_ADD], op_seen[OP_SUB], op_seen[OP_MUL],
             op_seen[OP_HALT] + op_seen[OP_UNSUP] + op_seen[OP_RSVD6] + op_seen[OP_RSVD7]);
    $display("Checked %0d items, %0d allocation errors, %0d mismatches",
             ledger.bytes_checked, ledger.alloc_errors, ledger.mismatches);
    if (ledger.mismatches == 0 && ledger.pending_bytes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/x86enc_pkg.sv
hw/rtl/x86enc_front.sv
hw/rtl/x86enc_queue.sv
hw/rtl/x86enc_back.sv
hw/rtl/ir_to_x86_instruction_encoder.sv
tb/ir_to_x86_instruction_encoder_tb.sv
